### design/gtod_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gtod_pkg;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_PPS  = 2'd1,
    OP_BYTE = 2'd2
  } op_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } hms_t;

  typedef struct packed {
    logic valid;
    hms_t tod;
  } load_t;

  localparam logic [9:0] MS_TOP      = 10'd999;
  localparam logic [5:0] MIN_SEC_TOP = 6'd59;
  localparam logic [4:0] HOUR_TOP    = 5'd23;
  localparam logic [31:0] MS_PER_PPS = 32'd1000;

  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;

  localparam logic REG_UTC_OFFSET      = 1'b0;
  localparam logic REG_REPORT_INTERVAL = 1'b1;

  localparam logic [4:0] UTC_OFFSET_RESET      = 5'd1;
  localparam logic [7:0] REPORT_INTERVAL_RESET = 8'd5;

endpackage

`default_nettype wire

### design/gtod_nmea_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module gtod_nmea_parser (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           byte_valid,
  input  wire logic [7:0]     rx_byte,
  input  wire logic [4:0]     utc_offset,
  output gtod_pkg::load_t     load
);

  logic [7:0] recent_r   [0:2];
  logic [7:0] recent_nxt [0:2];
  logic [7:0] digit_r    [0:5];
  logic [7:0] digit_nxt  [0:5];
  logic       capturing_r, capturing_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       synced_r, synced_nxt;

  logic [5:0] hh_pair;
  logic [4:0] hh_raw;
  logic [6:0] h_sum;
  logic [4:0] hh;

  function automatic logic [5:0] pair_value(input logic [7:0] d0, input logic [7:0] d1,
                                             input logic [5:0] top);
    logic signed [12:0] v;
    logic [5:0] res;
    v = ($signed({5'b0, d0}) - 13'sd48) * 13'sd10 + ($signed({5'b0, d1}) - 13'sd48);
    if (v < 13'sd0) begin
      res = 6'd0;
    end else if (v > $signed({7'b0, top})) begin
      res = top;
    end else begin
      res = v[5:0];
    end
    return res;
  endfunction

  // hours with utc offset, wrap modulo 24
  always_comb begin
    hh_pair = pair_value(digit_r[0], digit_r[1], {1'b0, gtod_pkg::HOUR_TOP});
    hh_raw  = hh_pair[4:0];
    h_sum   = {2'b0, hh_raw} + {{2{utc_offset[4]}}, utc_offset} + 7'd24;
    if (h_sum >= 7'd48) begin
      hh = 5'(h_sum - 7'd48);
    end else if (h_sum >= 7'd24) begin
      hh = 5'(h_sum - 7'd24);
    end else begin
      hh = h_sum[4:0];
    end
  end

  always_comb begin
    recent_nxt    = recent_r;
    digit_nxt     = digit_r;
    capturing_nxt = capturing_r;
    idx_nxt       = idx_r;
    synced_nxt    = synced_r;
    load.valid    = 1'b0;
    load.tod.hours   = hh;
    load.tod.minutes = pair_value(digit_r[2], digit_r[3], gtod_pkg::MIN_SEC_TOP);
    load.tod.seconds = pair_value(digit_r[4], digit_r[5], gtod_pkg::MIN_SEC_TOP);
    if (byte_valid && !synced_r) begin
      if (idx_r > 3'd5) begin
        idx_nxt    = 3'd0;
        synced_nxt = 1'b1;
        load.valid = 1'b1;
      end else if (capturing_r) begin
        if (rx_byte == gtod_pkg::CHAR_COMMA) begin
          capturing_nxt = 1'b0;
        end
        for (int i = 0; i < 6; i++) begin
          if (idx_r == 3'(i)) begin
            digit_nxt[i] = rx_byte;
          end
        end
        idx_nxt = idx_r + 3'd1;
      end else begin
        recent_nxt[0] = recent_r[1];
        recent_nxt[1] = recent_r[2];
        recent_nxt[2] = rx_byte;
        if (recent_r[1] == gtod_pkg::CHAR_G && recent_r[2] == gtod_pkg::CHAR_A &&
            rx_byte == gtod_pkg::CHAR_COMMA) begin
          capturing_nxt = 1'b1;
          idx_nxt       = 3'd0;
          recent_nxt[0] = 8'd0;
          recent_nxt[1] = 8'd0;
          recent_nxt[2] = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        recent_r[i] <= 8'd0;
      end
      for (int i = 0; i < 6; i++) begin
        digit_r[i] <= 8'd0;
      end
      capturing_r <= 1'b0;
      idx_r       <= 3'd0;
      synced_r    <= 1'b0;
    end else begin
      recent_r    <= recent_nxt;
      digit_r     <= digit_nxt;
      capturing_r <= capturing_nxt;
      idx_r       <= idx_nxt;
      synced_r    <= synced_nxt;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n) idx_r <= 3'd6)
    else $error("capture index out of range");

  a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
    load.valid |-> byte_valid && !synced_r)
    else $error("time load without a fresh byte");

  a_load_hours: assert property (@(posedge clk) disable iff (!rst_n)
    load.tod.hours <= gtod_pkg::HOUR_TOP)
    else $error("loaded hours out of range");

endmodule

`default_nettype wire

### design/gtod_clock_core.sv
`timescale 1ns / 1ps
`default_nettype none

module gtod_clock_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             evt_valid,
  input  wire gtod_pkg::op_t    evt_op,
  input  wire gtod_pkg::load_t  load,
  input  wire logic [7:0]       report_interval,
  output logic                  slot_free,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output logic [79:0]           res_data
);

  logic            running_r, running_nxt;
  gtod_pkg::hms_t  board_r, board_nxt;
  logic [9:0]      board_ms_r, board_ms_nxt;
  gtod_pkg::hms_t  gps_r, gps_nxt;
  logic [31:0]     board_cnt_r, board_cnt_nxt;
  logic [31:0]     gps_cnt_r, gps_cnt_nxt;
  logic [31:0]     last_diff_r, last_diff_nxt;
  logic [7:0]      phase_r, phase_nxt;
  logic [7:0]      interval;
  logic [8:0]      phase_sum;
  logic [31:0]     diff;

  logic            res_valid_r, res_valid_nxt;
  gtod_pkg::hms_t  res_board_r, res_board_nxt;
  logic [9:0]      res_ms_r, res_ms_nxt;
  gtod_pkg::hms_t  res_gps_r, res_gps_nxt;
  logic [31:0]     res_drift_r, res_drift_nxt;

  function automatic gtod_pkg::hms_t add_second(input gtod_pkg::hms_t t);
    gtod_pkg::hms_t r;
    r = t;
    if (t.seconds >= gtod_pkg::MIN_SEC_TOP) begin
      r.seconds = 6'd0;
      if (t.minutes >= gtod_pkg::MIN_SEC_TOP) begin
        r.minutes = 6'd0;
        if (t.hours >= gtod_pkg::HOUR_TOP) begin
          r.hours = 5'd0;
        end else begin
          r.hours = t.hours + 5'd1;
        end
      end else begin
        r.minutes = t.minutes + 6'd1;
      end
    end else begin
      r.seconds = t.seconds + 6'd1;
    end
    return r;
  endfunction

  assign slot_free = !res_valid_r || res_ready;
  assign res_valid = res_valid_r;
  assign res_data  = {4'b0, res_drift_r, res_gps_r.seconds, res_gps_r.minutes,
                      res_gps_r.hours, res_ms_r, res_board_r.seconds,
                      res_board_r.minutes, res_board_r.hours};

  assign interval  = (report_interval == 8'd0) ? 8'd1 : report_interval;
  assign phase_sum = {1'b0, phase_r} + 9'd1;

  always_comb begin
    running_nxt   = running_r;
    board_nxt     = board_r;
    board_ms_nxt  = board_ms_r;
    gps_nxt       = gps_r;
    board_cnt_nxt = board_cnt_r;
    gps_cnt_nxt   = gps_cnt_r;
    last_diff_nxt = last_diff_r;
    phase_nxt     = phase_r;
    res_valid_nxt = res_ready ? 1'b0 : res_valid_r;
    res_board_nxt = res_board_r;
    res_ms_nxt    = res_ms_r;
    res_gps_nxt   = res_gps_r;
    res_drift_nxt = res_drift_r;
    diff          = 32'd0;
    if (evt_valid) begin
      case (evt_op)
        gtod_pkg::OP_TICK: begin
          if (running_r) begin
            board_cnt_nxt = board_cnt_r + 32'd1;
            if (board_ms_r >= gtod_pkg::MS_TOP) begin
              board_ms_nxt = 10'd0;
              board_nxt    = add_second(board_r);
            end else begin
              board_ms_nxt = board_ms_r + 10'd1;
            end
          end
        end
        gtod_pkg::OP_PPS: begin
          if (!running_r) begin
            running_nxt = 1'b1;
          end else begin
            gps_cnt_nxt = gps_cnt_r + gtod_pkg::MS_PER_PPS;
          end
          gps_nxt = add_second(gps_r);
          diff    = gps_cnt_nxt - board_cnt_r;
          if (phase_r == 8'd0) begin
            res_valid_nxt = 1'b1;
            res_board_nxt = board_r;
            res_ms_nxt    = board_ms_r;
            res_gps_nxt   = gps_nxt;
            res_drift_nxt = diff - last_diff_r;
            last_diff_nxt = diff;
          end
          phase_nxt = (phase_sum >= {1'b0, interval}) ? 8'd0 : phase_sum[7:0];
        end
        gtod_pkg::OP_BYTE: begin
          if (load.valid) begin
            board_nxt = load.tod;
            gps_nxt   = load.tod;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      board_r     <= '0;
      board_ms_r  <= 10'd0;
      gps_r       <= '0;
      board_cnt_r <= 32'd0;
      gps_cnt_r   <= 32'd0;
      last_diff_r <= 32'd0;
      phase_r     <= 8'd0;
      res_valid_r <= 1'b0;
    end else begin
      running_r   <= running_nxt;
      board_r     <= board_nxt;
      board_ms_r  <= board_ms_nxt;
      gps_r       <= gps_nxt;
      board_cnt_r <= board_cnt_nxt;
      gps_cnt_r   <= gps_cnt_nxt;
      last_diff_r <= last_diff_nxt;
      phase_r     <= phase_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_board_r <= res_board_nxt;
    res_ms_r    <= res_ms_nxt;
    res_gps_r   <= res_gps_nxt;
    res_drift_r <= res_drift_nxt;
  end

  a_board_range: assert property (@(posedge clk) disable iff (!rst_n)
    board_ms_r <= gtod_pkg::MS_TOP && board_r.seconds <= gtod_pkg::MIN_SEC_TOP &&
    board_r.minutes <= gtod_pkg::MIN_SEC_TOP && board_r.hours <= gtod_pkg::HOUR_TOP)
    else $error("board time out of range");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> board_cnt_r == 32'd0 && gps_cnt_r == 32'd0)
    else $error("counts moved before first pps");

  a_run_sticky: assert property (@(posedge clk) disable iff (!rst_n) !$fell(running_r))
    else $error("clock stopped after start");

endmodule

`default_nettype wire

### design/gps_synced_time_of_day_clock_top.sv
// An input beat reaches its report beat through the input register and the result register.
// Throughput: one input beat per cycle; only a stalled report beat holds back the input.
// Every event is handled in one pass of carry and compare logic after the input register.
// Reset (rst_n, synchronous, active low) stops both clocks, clears counts and parser,
// and sets utc_offset to 1 and report_interval to 5.
`timescale 1ns / 1ps
`default_nettype none

module gps_synced_time_of_day_clock_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // rx_byte[7:0]
  input  wire logic [1:0]  in_tuser,   // op[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // board_hours[4:0], board_minutes[10:5], board_seconds[16:11], board_millis[26:17],
  // gps_hours[31:27], gps_minutes[37:32], gps_seconds[43:38], drift_change[75:44], pad
  output logic [79:0]      out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic            in_valid_r;
  gtod_pkg::op_t   in_op_r;
  logic [7:0]      in_byte_r;
  logic [4:0]      utc_offset_r;
  logic [7:0]      report_interval_r;
  logic            slot_free;
  logic            advance;
  logic            cfg_wr;
  gtod_pkg::load_t load;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign advance    = in_valid_r && slot_free;
  assign in_tready  = !in_valid_r || slot_free;

  always_comb begin
    case (cfg_paddr[2])
      gtod_pkg::REG_UTC_OFFSET:      cfg_prdata = {27'd0, utc_offset_r};
      gtod_pkg::REG_REPORT_INTERVAL: cfg_prdata = {24'd0, report_interval_r};
      default:                       cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      utc_offset_r      <= gtod_pkg::UTC_OFFSET_RESET;
      report_interval_r <= gtod_pkg::REPORT_INTERVAL_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == gtod_pkg::REG_UTC_OFFSET) begin
        utc_offset_r <= cfg_pwdata[4:0];
      end else begin
        report_interval_r <= cfg_pwdata[7:0];
      end
    end
  end

  // hold the input beat until the core can take it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r   <= gtod_pkg::op_t'(in_tuser);
      in_byte_r <= in_tdata;
    end
  end

  gtod_nmea_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (advance && in_op_r == gtod_pkg::OP_BYTE),
    .rx_byte    (in_byte_r),
    .utc_offset (utc_offset_r),
    .load       (load)
  );

  gtod_clock_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .evt_valid       (advance),
    .evt_op          (in_op_r),
    .load            (load),
    .report_interval (report_interval_r),
    .slot_free       (slot_free),
    .res_valid       (out_tvalid),
    .res_ready       (out_tready),
    .res_data        (out_tdata)
  );

endmodule

`default_nettype wire

### sim/gps_synced_time_of_day_clock_top_test.sv
`timescale 1ns / 1ps

module gps_synced_time_of_day_clock_top_test;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_UTC_OFFSET = {gtod_pkg::REG_UTC_OFFSET, 2'b00};
  localparam logic [2:0] ADDR_REPORT_INTERVAL = {gtod_pkg::REG_REPORT_INTERVAL, 2'b00};
  localparam int ASCII_ZERO = 48;
  localparam int DUT_LATENCY = 2;
  localparam int IDLE_PCT = 22;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [9:0] millis;
  } tod_t;

  typedef struct packed {
    logic [3:0]  pad;
    logic [31:0] drift_change;
    logic [5:0]  gps_seconds;
    logic [5:0]  gps_minutes;
    logic [4:0]  gps_hours;
    logic [9:0]  board_millis;
    logic [5:0]  board_seconds;
    logic [5:0]  board_minutes;
    logic [4:0]  board_hours;
  } report_t;

  class clock_tracker;
    bit          running;
    tod_t        board;
    tod_t        gps;
    logic [31:0] board_ms_count;
    logic [31:0] gps_ms_count;
    logic [31:0] last_difference;
    int unsigned pps_phase;
    logic [7:0]  recent [3];
    bit          capturing;
    int unsigned capture_index;
    logic [7:0]  digits [6];
    bit          synced;
    logic [4:0]  utc_offset = gtod_pkg::UTC_OFFSET_RESET;
    logic [7:0]  report_interval = gtod_pkg::REPORT_INTERVAL_RESET;
    report_t     due_reports [$];
    int          events;
    int          reports_checked;
    int          errors;

    function new();
      board = '0;
      gps = '0;
      board_ms_count = '0;
      gps_ms_count = '0;
      last_difference = '0;
      foreach (recent[k]) recent[k] = '0;
      foreach (digits[k]) digits[k] = '0;
    endfunction

    function void set_register(logic [2:0] addr, logic [31:0] value);
      if (addr == ADDR_UTC_OFFSET) utc_offset = value[4:0];
      else if (addr == ADDR_REPORT_INTERVAL) report_interval = value[7:0];
    endfunction

    function tod_t next_second(tod_t t);
      t.millis = '0;
      if (t.seconds >= gtod_pkg::MIN_SEC_TOP) begin
        t.seconds = '0;
        if (t.minutes >= gtod_pkg::MIN_SEC_TOP) begin
          t.minutes = '0;
          t.hours = (t.hours >= gtod_pkg::HOUR_TOP) ? 5'd0 : t.hours + 5'd1;
        end else begin
          t.minutes++;
        end
      end else begin
        t.seconds++;
      end
      return t;
    endfunction

    function int pair_value(int pos, int top);
      int v;
      v = (int'({24'd0, digits[pos]}) - ASCII_ZERO) * 10 +
          (int'({24'd0, digits[pos + 1]}) - ASCII_ZERO);
      if (v < 0) v = 0;
      if (v > top) v = top;
      return v;
    endfunction

    function void load_clocks();
      int hh;
      int mm;
      int ss;
      hh = (pair_value(0, int'(gtod_pkg::HOUR_TOP)) + int'($signed(utc_offset)) + 24) % 24;
      mm = pair_value(2, int'(gtod_pkg::MIN_SEC_TOP));
      ss = pair_value(4, int'(gtod_pkg::MIN_SEC_TOP));
      board.hours = hh[4:0];
      board.minutes = mm[5:0];
      board.seconds = ss[5:0];
      gps.hours = hh[4:0];
      gps.minutes = mm[5:0];
      gps.seconds = ss[5:0];
    endfunction

    function void take_byte(logic [7:0] c);
      if (synced) return;
      if (capture_index > 5) begin
        capture_index = 0;
        load_clocks();
        synced = 1'b1;
        return;
      end
      if (capturing) begin
        if (c == gtod_pkg::CHAR_COMMA) capturing = 1'b0;
        digits[capture_index] = c;
        capture_index++;
      end else begin
        recent[0] = recent[1];
        recent[1] = recent[2];
        recent[2] = c;
        if (recent[0] == gtod_pkg::CHAR_G && recent[1] == gtod_pkg::CHAR_A &&
            recent[2] == gtod_pkg::CHAR_COMMA) begin
          capturing = 1'b1;
          capture_index = 0;
          foreach (recent[k]) recent[k] = '0;
        end
      end
    endfunction

    function void take_pps();
      int unsigned span;
      logic [31:0] diff;
      report_t     r;
      span = (report_interval == 8'd0) ? 1 : report_interval;
      if (!running) running = 1'b1;
      else gps_ms_count += gtod_pkg::MS_PER_PPS;
      gps = next_second(gps);
      if (pps_phase == 0) begin
        diff = gps_ms_count - board_ms_count;
        r = '0;
        r.board_hours = board.hours;
        r.board_minutes = board.minutes;
        r.board_seconds = board.seconds;
        r.board_millis = board.millis;
        r.gps_hours = gps.hours;
        r.gps_minutes = gps.minutes;
        r.gps_seconds = gps.seconds;
        r.drift_change = diff - last_difference;
        last_difference = diff;
        due_reports.push_back(r);
      end
      pps_phase++;
      if (pps_phase >= span) pps_phase = 0;
    endfunction

    function void note_event(logic [1:0] op, logic [7:0] data);
      events++;
      case (op)
        gtod_pkg::OP_TICK: begin
          if (running) begin
            board_ms_count++;
            if (board.millis >= gtod_pkg::MS_TOP) board = next_second(board);
            else board.millis++;
          end
        end
        gtod_pkg::OP_PPS: take_pps();
        gtod_pkg::OP_BYTE: take_byte(data);
        default: ;
      endcase
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %0d (0x%h), actual %0d (0x%h)",
                 $time, name, want, want, got, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_report(logic [79:0] data);
      report_t want;
      report_t got;
      bit      ok;
      if (due_reports.size() == 0) begin
        $display("%0t ns: unexpected report beat, expected none, actual 0x%h", $time, data);
        errors++;
        return;
      end
      want = due_reports.pop_front();
      got = data;
      ok = 1'b1;
      ok &= field_ok("board_hours", want.board_hours, got.board_hours);
      ok &= field_ok("board_minutes", want.board_minutes, got.board_minutes);
      ok &= field_ok("board_seconds", want.board_seconds, got.board_seconds);
      ok &= field_ok("board_millis", want.board_millis, got.board_millis);
      ok &= field_ok("gps_hours", want.gps_hours, got.gps_hours);
      ok &= field_ok("gps_minutes", want.gps_minutes, got.gps_minutes);
      ok &= field_ok("gps_seconds", want.gps_seconds, got.gps_seconds);
      ok &= field_ok("drift_change", want.drift_change, got.drift_change);
      if (!ok) errors++;
      reports_checked++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = gtod_pkg::OP_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bit           steady = 1'b0;
  clock_tracker clocks;

  gps_synced_time_of_day_clock_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    if (rst_n && out_tvalid && out_tready) clocks.check_report(out_tdata);
  end

  task automatic send_event(input logic [1:0] op, input logic [7:0] data);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    clocks.note_event(op, data);
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_event(gtod_pkg::OP_BYTE, s[k]);
  endtask

  // hold input low until every report is out, then let the pipeline settle
  task automatic wait_for_reports();
    in_tvalid <= 1'b0;
    while (clocks.due_reports.size() != 0) @(posedge clk);
    repeat (DUT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    clocks.set_register(addr, value);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int offset, input int interval);
    wait_for_reports();
    write_reg(ADDR_UTC_OFFSET, 32'(offset));
    write_reg(ADDR_REPORT_INTERVAL, 32'(interval));
  endtask

  task automatic run_phase(input int count, input int pps_pct, input int pause_at);
    int roll;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) wait_for_reports();
      roll = $urandom_range(99);
      if (roll < pps_pct) send_event(gtod_pkg::OP_PPS, 8'($urandom_range(255)));
      else if (roll < pps_pct + 2) send_event(gtod_pkg::OP_BYTE, 8'($urandom_range(255)));
      else if (roll < pps_pct + 3) send_event(OP_UNUSED, 8'($urandom_range(255)));
      else send_event(gtod_pkg::OP_TICK, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    clocks = new();
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(-1, 1);
    send_event(OP_UNUSED, 8'hFF);
    send_event(gtod_pkg::OP_TICK, 8'h00);
    // comma inside the capture ends it early, then a fresh header restarts it
    send_text("GA,12,");
    send_text("x");
    // hours go negative and clamp to 0 before the offset wraps them, minutes clamp to 59
    send_text("GA,/56:59");
    send_event(gtod_pkg::OP_PPS, 8'hA5);
    send_event(gtod_pkg::OP_TICK, 8'h00);
    send_event(gtod_pkg::OP_TICK, 8'h3C);
    send_event(gtod_pkg::OP_BYTE, 8'h00);
    send_event(gtod_pkg::OP_BYTE, 8'h80);
    send_event(gtod_pkg::OP_PPS, 8'h00);
    send_event(gtod_pkg::OP_TICK, 8'h00);
    send_event(gtod_pkg::OP_PPS, 8'h00);

    set_config(14, 1);
    run_phase(500, 4, -1);
    set_config(-12, 255);
    run_phase(200, 45, -1);
    set_config(int'($urandom_range(26)) - 12, 3);
    run_phase(200, 12, 100);
    set_config(int'($urandom_range(26)) - 12, 0);
    steady = 1'b1;
    run_phase(200, 15, -1);
    steady = 1'b0;
    set_config(int'($urandom_range(26)) - 12, $urandom_range(1, 8));
    run_phase(150, 8, -1);

    wait_for_reports();
    repeat (DUT_LATENCY + 6) @(posedge clk);
    $display("Drove %0d events through sync, clock rollovers and six register settings;",
             clocks.events);
    $display("%0d time reports compared, %0d failed.", clocks.reports_checked, clocks.errors);
    if (clocks.due_reports.size() != 0)
      $display("%0d expected reports never arrived", clocks.due_reports.size());
    if (clocks.errors == 0 && clocks.due_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Run timed out with %0d reports outstanding", clocks.due_reports.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
